[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the decoder top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/htwd_pkg.sv]
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types and constants of the tree-walk decoder.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int INDEX_W  = 8;  // width of the node index fields on the ports
    localparam int SYMBOL_W = 8;  // width of the symbol fields on the ports

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_HOLD
    } st_t;

    // How the current transaction finishes.
    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_PLAIN,
        FIN_STUCK,
        FIN_CHECK
    } fin_t;

    typedef struct packed {
        logic from_in;    // item fields come straight from the input ports
        logic use_rd;     // current node entry comes from the read data
        logic capture;    // latch the accepted item
        logic mem_wr;     // write one node entry
        logic rd_cur;     // read the entry at the cursor
        logic rd_child;   // read the entry of the selected child
        logic take_cur;   // cache the read data as the current node entry
        fin_t fin;
        logic emit_live;  // load the output register with the live result
        logic emit_held;  // load the output register with the held result
    } ctrl_cmd_t;

    typedef struct packed {
        logic stuck;
        logic cur_ok;
        logic child_present;
        logic out_free;
    } ctrl_sts_t;

endpackage

[rtl/core/huffman_tree_walk_decoder_top.sv]
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top
// Bit-serial Huffman decoder walking a code tree held in a node memory.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | kind, node_index, node_symbol, links,
//          |                      | code_bit, last_bit
//  out     | out_valid / out_ready| symbol_valid, symbol, stuck
//  cfg     | cfg_valid / cfg_ready| root_index
//
//  Load item: IDLE. Decode bit: IDLE, CHECK with the current node's entry cached, IDLE,
//  FETCH, CHECK when it must first be read (after reset, a symbol, a last bit, a root
//  write or a load over the current node). A bit taken while stuck: IDLE; an absent
//  child: IDLE, or FETCH with the read. The single-port node memory with registered
//  read sets this. One item is in flight; a result waiting on out_ready blocks the next
//  one. Reset clears cursor, stuck flag and root; the node memory is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_walk_decoder_top
    import htwd_pkg::*;
#(
    parameter int NODE_COUNT  = 256,
    parameter int SYMBOL_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [INDEX_W-1:0]  node_index,
    input  logic [SYMBOL_W-1:0] node_symbol,
    input  logic [INDEX_W-1:0]  left_child,
    input  logic                left_present,
    input  logic [INDEX_W-1:0]  right_child,
    input  logic                right_present,
    input  logic                code_bit,
    input  logic                last_bit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                symbol_valid,
    output logic [SYMBOL_W-1:0] symbol,
    output logic                stuck,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  root_index
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      cfg_we;

    // the user must send writes only while idle, the block does not enforce it; the register is always ready
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    htwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    htwd_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .root_index    (root_index),
        .kind          (kind),
        .node_index    (node_index),
        .node_symbol   (node_symbol),
        .left_child    (left_child),
        .left_present  (left_present),
        .right_child   (right_child),
        .right_present (right_present),
        .code_bit      (code_bit),
        .last_bit      (last_bit),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .symbol_valid  (symbol_valid),
        .symbol        (symbol),
        .stuck         (stuck)
    );

    `ASSERT_IMPLIES(a_sym_zero, clk, rst_n, out_valid && !symbol_valid, symbol == '0, "symbol not zero without symbol_valid")

    `ASSERT_NEXT(a_load_result, clk, rst_n, in_valid && in_ready && !kind && (!out_valid || out_ready), out_valid && !symbol_valid, "load transaction result missing")

    `ASSERT_NEXT(a_pending_blocks, clk, rst_n, in_valid && in_ready && !kind && out_valid && !out_ready, !in_ready, "new transaction taken while result pending")

endmodule

[rtl/core/htwd_ctrl.sv]
// ----------------------------------------------------------------------------
// htwd_ctrl
// Sequencer of the tree-walk decoder: one item at a time.
// ----------------------------------------------------------------------------
module htwd_ctrl
    import htwd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      kind,
    input  ctrl_sts_t sts,
    output logic      in_ready,
    output ctrl_cmd_t cmd
);

    st_t state_reg;
    st_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.fin      = FIN_NONE;
        in_ready     = 1'b0;
        // selectors depend on the state only, never on status
        cmd.from_in  = (state_reg == ST_IDLE);
        cmd.use_rd   = (state_reg == ST_FETCH);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!kind)
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.fin    = FIN_PLAIN;
                    end
                    else if (sts.stuck)
                    begin
                        cmd.fin = FIN_PLAIN;
                    end
                    else if (!sts.cur_ok)
                    begin
                        cmd.rd_cur = 1'b1;
                        state_next = ST_FETCH;
                    end
                    else if (!sts.child_present)
                    begin
                        cmd.fin = FIN_STUCK;
                    end
                    else
                    begin
                        cmd.rd_child = 1'b1;
                        state_next   = ST_CHECK;
                    end
                end
            end

            ST_FETCH:
            begin
                cmd.take_cur = 1'b1;
                if (!sts.child_present)
                begin
                    cmd.fin = FIN_STUCK;
                end
                else
                begin
                    cmd.rd_child = 1'b1;
                    state_next   = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                cmd.fin = FIN_CHECK;
            end

            ST_HOLD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result goes out now if the output register is free, else it waits
        if (cmd.fin != FIN_NONE)
        begin
            if (sts.out_free)
            begin
                cmd.emit_live = 1'b1;
                state_next    = ST_IDLE;
            end
            else
            begin
                state_next = ST_HOLD;
            end
        end
    end

endmodule

[rtl/core/htwd_datapath.sv]
// ----------------------------------------------------------------------------
// htwd_datapath
// Node memory, cursor, stuck flag, cached current node and output register.
// ----------------------------------------------------------------------------
module htwd_datapath
    import htwd_pkg::*;
#(
    parameter int NODE_COUNT  = 256,
    parameter int SYMBOL_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic                cfg_we,
    input  logic [INDEX_W-1:0]  root_index,
    input  logic                kind,
    input  logic [INDEX_W-1:0]  node_index,
    input  logic [SYMBOL_W-1:0] node_symbol,
    input  logic [INDEX_W-1:0]  left_child,
    input  logic                left_present,
    input  logic [INDEX_W-1:0]  right_child,
    input  logic                right_present,
    input  logic                code_bit,
    input  logic                last_bit,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                symbol_valid,
    output logic [SYMBOL_W-1:0] symbol,
    output logic                stuck
);

    localparam int IW       = $clog2(NODE_COUNT);
    localparam int WRAP_LEN = 1 << INDEX_W;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] sym;
        logic [IW-1:0]          left;
        logic                   left_ok;
        logic [IW-1:0]          right;
        logic                   right_ok;
    } node_t;

    // index wrap table: any 8-bit index modulo the store depth
    logic [IW-1:0] wrap_lut [WRAP_LEN];

    for (genvar g = 0; g < WRAP_LEN; g++)
    begin : g_wrap
        assign wrap_lut[g] = IW'(g % NODE_COUNT);
    end

    node_t node_mem [NODE_COUNT];

    logic [IW-1:0]          root_reg,   root_next;
    logic [IW-1:0]          cursor_reg, cursor_next;
    logic                   stuck_reg,  stuck_next;
    logic                   cur_ok_reg, cur_ok_next;
    node_t                  cur_node_reg, cur_node_next;
    node_t                  rd_data_reg;
    logic [IW-1:0]          child_reg;
    logic                   kind_reg, bit_reg, last_reg;
    logic                   res_valid_reg, res_stuck_reg;
    logic [SYMBOL_W-1:0]    res_sym_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_sv_reg, out_stuck_reg;
    logic [SYMBOL_W-1:0]    out_sym_reg;

    node_t                  cur_src;
    node_t                  wr_node;
    logic [IW-1:0]          wr_addr;
    logic [IW-1:0]          rd_addr;
    logic [IW-1:0]          child_addr;
    logic                   bit_now, last_now, kind_now;
    logic                   live_valid, live_stuck;
    logic [SYMBOL_W-1:0]    live_sym;

    assign bit_now  = cmd.from_in ? code_bit : bit_reg;
    assign last_now = cmd.from_in ? last_bit : last_reg;
    assign kind_now = cmd.from_in ? kind     : kind_reg;
    assign cur_src  = cmd.use_rd  ? rd_data_reg : cur_node_reg;

    assign child_addr = bit_now ? cur_src.right : cur_src.left;
    assign rd_addr    = cmd.rd_cur ? cursor_reg : child_addr;

    assign wr_addr          = wrap_lut[node_index];
    assign wr_node.sym      = SYMBOL_BITS'(node_symbol);
    assign wr_node.left     = wrap_lut[left_child];
    assign wr_node.left_ok  = left_present;
    assign wr_node.right    = wrap_lut[right_child];
    assign wr_node.right_ok = right_present;

    assign sts.stuck         = stuck_reg;
    assign sts.cur_ok        = cur_ok_reg;
    assign sts.child_present = bit_now ? cur_src.right_ok : cur_src.left_ok;
    assign sts.out_free      = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            node_mem[wr_addr] <= wr_node;
        end
        if (cmd.rd_cur || cmd.rd_child)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    always_comb
    begin
        root_next     = root_reg;
        cursor_next   = cursor_reg;
        stuck_next    = stuck_reg;
        cur_ok_next   = cur_ok_reg;
        cur_node_next = cur_node_reg;
        live_valid    = 1'b0;
        live_sym      = '0;
        live_stuck    = stuck_reg;

        if (cfg_we)
        begin
            root_next   = wrap_lut[root_index];
            cursor_next = wrap_lut[root_index];
            cur_ok_next = 1'b0;
        end

        // a load over the current node drops the cached copy
        if (cmd.mem_wr && (wr_addr == cursor_reg))
        begin
            cur_ok_next = 1'b0;
        end

        if (cmd.take_cur)
        begin
            cur_node_next = rd_data_reg;
            cur_ok_next   = 1'b1;
        end

        case (cmd.fin)
            FIN_STUCK:
            begin
                stuck_next = 1'b1;
                live_stuck = 1'b1;
            end

            FIN_CHECK:
            begin
                if (rd_data_reg.sym != '0)
                begin
                    live_valid  = 1'b1;
                    live_sym    = SYMBOL_W'(rd_data_reg.sym);
                    cursor_next = root_reg;
                    cur_ok_next = 1'b0;
                end
                else
                begin
                    cursor_next   = child_reg;
                    cur_node_next = rd_data_reg;
                    cur_ok_next   = 1'b1;
                end
            end

            default:
            begin
            end
        endcase

        // end of message: the walk restarts when the last bit's item finishes
        if ((cmd.fin != FIN_NONE) && kind_now && last_now)
        begin
            cursor_next = root_reg;
            stuck_next  = 1'b0;
            cur_ok_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_live || cmd.emit_held)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            cursor_reg    <= '0;
            stuck_reg     <= 1'b0;
            cur_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            root_reg      <= root_next;
            cursor_reg    <= cursor_next;
            stuck_reg     <= stuck_next;
            cur_ok_reg    <= cur_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_node_reg <= cur_node_next;
        if (cmd.capture)
        begin
            kind_reg <= kind;
            bit_reg  <= code_bit;
            last_reg <= last_bit;
        end
        if (cmd.rd_child)
        begin
            child_reg <= child_addr;
        end
        if (cmd.fin != FIN_NONE)
        begin
            res_valid_reg <= live_valid;
            res_sym_reg   <= live_sym;
            res_stuck_reg <= live_stuck;
        end
        if (cmd.emit_live)
        begin
            out_sv_reg    <= live_valid;
            out_sym_reg   <= live_sym;
            out_stuck_reg <= live_stuck;
        end
        else if (cmd.emit_held)
        begin
            out_sv_reg    <= res_valid_reg;
            out_sym_reg   <= res_sym_reg;
            out_stuck_reg <= res_stuck_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_valid = out_sv_reg;
    assign symbol       = out_sym_reg;
    assign stuck        = out_stuck_reg;

endmodule

[verif/htwd_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htwd_tb_pkg
// Item kinds and the input transaction layout shared by the decoder bench.
// ----------------------------------------------------------------------------
package htwd_tb_pkg;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_BIT  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t                      kind;
        logic [htwd_pkg::INDEX_W-1:0]    node_index;
        logic [htwd_pkg::SYMBOL_W-1:0]   node_symbol;
        logic [htwd_pkg::INDEX_W-1:0]    left_child;
        logic                            left_present;
        logic [htwd_pkg::INDEX_W-1:0]    right_child;
        logic                            right_present;
        logic                            code_bit;
        logic                            last_bit;
    } code_item_t;

endpackage

[verif/htwd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htwd_checker
// Watches the decoder's input, output and root register channels, keeps its
// own copy of the node store and walk state, and compares every result.
// ----------------------------------------------------------------------------
module htwd_checker
    import htwd_pkg::*;
    import htwd_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                kind,
    input  logic [INDEX_W-1:0]  node_index,
    input  logic [SYMBOL_W-1:0] node_symbol,
    input  logic [INDEX_W-1:0]  left_child,
    input  logic                left_present,
    input  logic [INDEX_W-1:0]  right_child,
    input  logic                right_present,
    input  logic                code_bit,
    input  logic                last_bit,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                symbol_valid,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic                stuck,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [INDEX_W-1:0]  root_index,
    output int                  mismatches,
    output int                  pending,
    output int                  n_symbols,
    output int                  n_stuck
);

    typedef struct packed {
        logic [SYMBOL_W-1:0] sym;
        logic [INDEX_W-1:0]  left_idx;
        logic                left_ok;
        logic [INDEX_W-1:0]  right_idx;
        logic                right_ok;
    } tree_node_t;

    typedef struct packed {
        logic                hit;
        logic [SYMBOL_W-1:0] sym;
        logic                stuck;
    } decode_res_t;

    tree_node_t         node_mem [0:(1 << INDEX_W)-1];
    logic [INDEX_W-1:0] root_q;
    logic [INDEX_W-1:0] cursor_q;
    logic               stuck_q;
    decode_res_t        expected_q [$];
    int                 n_results;

    initial begin
        mismatches = 0;
        pending    = 0;
        n_symbols  = 0;
        n_stuck    = 0;
        n_results  = 0;
    end

    // Sampled on the falling edge: a transaction seen here completes at the
    // next rising edge, and nothing on the channels moves in between.
    always @(negedge clk or negedge rst_n) begin : monitor
        decode_res_t        res;
        decode_res_t        want;
        tree_node_t         cur;
        tree_node_t         nxt;
        logic               present;
        logic [INDEX_W-1:0] next_idx;

        if (!rst_n) begin
            root_q   = '0;
            cursor_q = '0;
            stuck_q  = 1'b0;
            expected_q.delete();
            pending  = 0;
        end else begin
            // results first, so a result never meets the item accepted with it
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result %0d arrived with nothing expected",
                                 $realtime, n_results);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.hit !== symbol_valid || want.sym !== symbol ||
                        want.stuck !== stuck) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch on result %0d: ", $realtime, n_results,
                                     "expected hit=%0b symbol=%02h stuck=%0b, ",
                                     want.hit, want.sym, want.stuck,
                                     "got hit=%0b symbol=%02h stuck=%0b",
                                     symbol_valid, symbol, stuck);
                        mismatches++;
                    end
                end
                if (symbol_valid === 1'b1) n_symbols++;
                if (stuck === 1'b1) n_stuck++;
                n_results++;
            end

            if (cfg_valid && cfg_ready) begin
                root_q   = root_index;
                cursor_q = root_index;  // walk restarts, stuck flag kept
            end

            if (in_valid && in_ready) begin
                res = '0;
                if (kind == KIND_LOAD) begin
                    cur.sym       = node_symbol;
                    cur.left_idx  = left_child;
                    cur.left_ok   = left_present;
                    cur.right_idx = right_child;
                    cur.right_ok  = right_present;
                    node_mem[node_index] = cur;
                end else if (!stuck_q) begin
                    cur      = node_mem[cursor_q];
                    present  = code_bit ? cur.right_ok  : cur.left_ok;
                    next_idx = code_bit ? cur.right_idx : cur.left_idx;
                    if (!present) begin
                        stuck_q = 1'b1;
                    end else begin
                        nxt = node_mem[next_idx];
                        // any nonzero symbol ends the code word
                        if (nxt.sym != '0) begin
                            res.hit  = 1'b1;
                            res.sym  = nxt.sym;
                            cursor_q = root_q;
                        end else begin
                            cursor_q = next_idx;
                        end
                    end
                end
                res.stuck = stuck_q;
                if (kind == KIND_BIT && last_bit) begin
                    cursor_q = root_q;
                    stuck_q  = 1'b0;
                end
                expected_q.push_back(res);
            end

            pending = expected_q.size();
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the tree-walk decoder with node loads and code bit streams built
// from random code trees, plus directed corner cases and noise; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench
    import htwd_pkg::*;
    import htwd_tb_pkg::*;
();

    localparam int ITEM_TARGET  = 1450;  // fill and directed items included
    localparam int QUIET_FROM   = 1250;  // no idling on either side after this
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_LEAVES   = 40;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                kind;
    logic [INDEX_W-1:0]  node_index;
    logic [SYMBOL_W-1:0] node_symbol;
    logic [INDEX_W-1:0]  left_child;
    logic                left_present;
    logic [INDEX_W-1:0]  right_child;
    logic                right_present;
    logic                code_bit;
    logic                last_bit;
    logic                out_valid;
    logic                out_ready;
    logic                symbol_valid;
    logic [SYMBOL_W-1:0] symbol;
    logic                stuck;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  root_index;

    int mismatches;
    int pending;
    int n_symbols;
    int n_stuck;

    int  n_items;
    int  n_roots;
    int  n_trees;
    int  cycles;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  hold_req;

    // code words of the current tree, first bit at position len-1
    logic [63:0] leaf_code [MAX_LEAVES];
    int          leaf_len  [MAX_LEAVES];
    int          n_leaves;

    huffman_tree_walk_decoder_top i_dut (.*);

    htwd_checker i_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic code_item_t rand_item();
        code_item_t it;
        it.kind          = item_kind_t'($urandom_range(0, 1));
        it.node_index    = INDEX_W'($urandom_range(0, 255));
        it.node_symbol   = SYMBOL_W'($urandom_range(0, 255));
        it.left_child    = INDEX_W'($urandom_range(0, 255));
        it.left_present  = 1'($urandom_range(0, 1));
        it.right_child   = INDEX_W'($urandom_range(0, 255));
        it.right_present = 1'($urandom_range(0, 1));
        it.code_bit      = 1'($urandom_range(0, 1));
        it.last_bit      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_item(input code_item_t it);
        bit acc;
        in_valid      <= 1'b1;
        kind          <= it.kind;
        node_index    <= it.node_index;
        node_symbol   <= it.node_symbol;
        left_child    <= it.left_child;
        left_present  <= it.left_present;
        right_child   <= it.right_child;
        right_present <= it.right_present;
        code_bit      <= it.code_bit;
        last_bit      <= it.last_bit;
        acc = 1'b0;
        while (!acc) begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end
        n_items++;
        if (tx_gaps && n_items < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic load_node(input logic [INDEX_W-1:0] idx, input logic [SYMBOL_W-1:0] sym,
                             input logic [INDEX_W-1:0] l, input logic lp,
                             input logic [INDEX_W-1:0] r, input logic rp);
        code_item_t it;
        it = rand_item();
        it.kind          = KIND_LOAD;
        it.node_index    = idx;
        it.node_symbol   = sym;
        it.left_child    = l;
        it.left_present  = lp;
        it.right_child   = r;
        it.right_present = rp;
        push_item(it);
    endtask

    task automatic decode_bit(input logic b, input logic last);
        code_item_t it;
        it = rand_item();
        it.kind     = KIND_BIT;
        it.code_bit = b;
        it.last_bit = last;
        push_item(it);
    endtask

    // Root writes only go in once every outstanding result has come back.
    task automatic write_root(input logic [INDEX_W-1:0] v);
        bit acc;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        cfg_valid  <= 1'b1;
        root_index <= v;
        acc = 1'b0;
        while (!acc) begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        n_roots++;
    endtask

    // Random full tree built by merging subtrees pairwise; the last merge
    // lands on the root. Children are loaded before their parents.
    task automatic build_tree(input logic [INDEX_W-1:0] root);
        int perm [256];
        int live_node [MAX_LEAVES];
        int live_grp [MAX_LEAVES];
        int owner [MAX_LEAVES];
        int n_live, alloc, g, k, j, t, na, nb, ga, gb, node;
        logic lp, rp;
        logic [SYMBOL_W-1:0] sym;

        for (k = 0; k < 256; k++) perm[k] = k;
        for (k = 255; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = perm[k];
            perm[k] = perm[j];
            perm[j] = t;
        end
        for (k = 0; k < 256; k++) begin
            if (perm[k] == root) begin
                perm[k] = perm[255];
                perm[255] = int'(root);
            end
        end

        n_leaves = ($urandom_range(0, 5) == 0) ? $urandom_range(13, MAX_LEAVES)
                                               : $urandom_range(2, 12);
        alloc = 0;
        for (k = 0; k < n_leaves; k++) begin
            node = perm[alloc];
            alloc++;
            leaf_code[k] = '0;
            leaf_len[k]  = 0;
            owner[k]     = k;
            live_node[k] = node;
            live_grp[k]  = k;
            // leaf links are never followed, so they carry random content
            load_node(INDEX_W'(node), SYMBOL_W'($urandom_range(1, 255)),
                      INDEX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      INDEX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        n_live = n_leaves;
        g = n_leaves;

        while (n_live > 1) begin
            j  = $urandom_range(0, n_live - 1);
            na = live_node[j];
            ga = live_grp[j];
            live_node[j] = live_node[n_live-1];
            live_grp[j]  = live_grp[n_live-1];
            n_live--;
            j  = $urandom_range(0, n_live - 1);
            nb = live_node[j];
            gb = live_grp[j];
            live_node[j] = live_node[n_live-1];
            live_grp[j]  = live_grp[n_live-1];
            n_live--;

            if (n_live == 0) begin
                node = int'(root);
            end else begin
                node = perm[alloc];
                alloc++;
            end

            for (k = 0; k < n_leaves; k++) begin
                if (owner[k] == ga) begin
                    leaf_len[k]++;
                    owner[k] = g;
                end else if (owner[k] == gb) begin
                    leaf_code[k] = leaf_code[k] | (64'd1 << leaf_len[k]);
                    leaf_len[k]++;
                    owner[k] = g;
                end
            end

            lp = 1'b1;
            rp = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) lp = 1'b0;
                else rp = 1'b0;
            end
            // the root's own symbol is never looked at
            sym = (node == root && $urandom_range(0, 3) == 0) ?
                  SYMBOL_W'($urandom_range(1, 255)) : '0;
            load_node(INDEX_W'(node), sym, INDEX_W'(na), lp, INDEX_W'(nb), rp);

            live_node[n_live] = node;
            live_grp[n_live]  = g;
            n_live++;
            g++;
        end
        n_trees++;
    endtask

    // A message of whole code words, with a sprinkling of stray items.
    task automatic send_message();
        code_item_t it;
        int words, w, k, b;
        words = $urandom_range(1, 12);
        for (w = 0; w < words; w++) begin
            k = $urandom_range(0, n_leaves - 1);
            for (b = leaf_len[k] - 1; b >= 0; b--) begin
                if ($urandom_range(0, 11) == 0) begin
                    it = rand_item();
                    if (it.kind == KIND_BIT && $urandom_range(0, 3) != 0) it.last_bit = 1'b0;
                    push_item(it);
                end
                decode_bit(leaf_code[k][b], w == words - 1 && b == 0);
            end
        end
    endtask

    initial begin : receiver
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (!rx_gaps || n_items >= QUIET_FROM) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        code_item_t           it;
        int                   phase, m, msgs, k;
        logic [INDEX_W-1:0]   root;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_LOAD;
        node_index    = '0;
        node_symbol   = '0;
        left_child    = '0;
        left_present  = 1'b0;
        right_child   = '0;
        right_present = 1'b0;
        code_bit      = 1'b0;
        last_bit      = 1'b0;
        cfg_valid     = 1'b0;
        root_index    = '0;
        n_items       = 0;
        n_roots       = 0;
        n_trees       = 0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_req      = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry gets written up front, so no walk reads stale memory
        for (k = 0; k < 256; k++) begin
            it = rand_item();
            it.kind       = KIND_LOAD;
            it.node_index = INDEX_W'(k);
            push_item(it);
        end

        // small hand-built tree at root 0:
        //   0 -> (1 leaf FF, 2) ; 2 -> (3 leaf 01, absent)
        load_node(8'd1, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1);  // leaf that has children
        load_node(8'd3, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0);
        load_node(8'd2, 8'h00, 8'd3, 1'b1, 8'hAA, 1'b0);
        load_node(8'd0, 8'h00, 8'd1, 1'b1, 8'd2, 1'b1);
        decode_bit(1'b0, 1'b0);
        decode_bit(1'b1, 1'b0);
        decode_bit(1'b0, 1'b0);
        decode_bit(1'b1, 1'b0);
        // rewrite the node under the cursor
        load_node(8'd2, 8'h00, 8'd3, 1'b1, 8'hFF, 1'b1);
        load_node(8'hFF, 8'h80, 8'h00, 1'b0, 8'h00, 1'b0);
        decode_bit(1'b1, 1'b0);
        decode_bit(1'b1, 1'b0);
        load_node(8'd2, 8'h00, 8'd3, 1'b1, 8'hFF, 1'b0);
        decode_bit(1'b1, 1'b0);                             // absent child
        decode_bit(1'b0, 1'b0);                             // ignored while stuck
        load_node(8'd3, 8'h01, 8'hFF, 1'b1, 8'hFF, 1'b1);
        decode_bit(1'b1, 1'b1);                             // last bit clears stuck
        decode_bit(1'b1, 1'b1);                             // last bit mid-word
        decode_bit(1'b0, 1'b1);                             // last bit on a leaf
        decode_bit(1'b1, 1'b0);
        decode_bit(1'b1, 1'b0);
        write_root(8'd2);                                   // written while stuck
        decode_bit(1'b0, 1'b0);
        decode_bit(1'b0, 1'b1);
        decode_bit(1'b0, 1'b0);
        decode_bit(1'b1, 1'b1);

        phase = 0;
        while (n_items < ITEM_TARGET) begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (phase == 0) root = '0;
            else if (phase == 1) root = '1;
            else root = INDEX_W'($urandom_range(0, 255));
            write_root(root);
            build_tree(root);
            msgs = $urandom_range(2, 5);
            for (m = 0; m < msgs; m++) begin
                // long output stall while the sender keeps offering bits
                if (phase == 2 && m == 1) hold_req = 1'b1;
                send_message();
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d input transactions over %0d code trees and %0d root writes.",
                 n_items, n_trees, n_roots);
        $display("Walks decoded %0d symbols; %0d results reported the stuck flag.",
                 n_symbols, n_stuck);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
